// File: rtl/core/utf8_latin1_glyph_mapper_defines.svh
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 glyph mapper: assertion macros
// Clocked, reset-qualified assertion wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_LATIN1_GLYPH_MAPPER_DEFINES_SVH
`define UTF8_LATIN1_GLYPH_MAPPER_DEFINES_SVH

// property must hold at every clock edge outside reset
`define U8GM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define U8GM_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/u8gm_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 glyph mapper package
// Shared types, register indices and character constants.
// ----------------------------------------------------------------------------
package u8gm_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [1:0] res_cnt_t;

	localparam int unsigned RES_MAX = 3;

	localparam byte_t QMARK           = 8'h3F;
	localparam byte_t FIRST_GLYPH_RST = 8'd32;
	localparam byte_t LAST_GLYPH_RST  = 8'd126;

	typedef enum logic {
		REG_FIRST_GLYPH = 1'b0,
		REG_LAST_GLYPH  = 1'b1
	} cfg_reg_t;

	function automatic logic is_cont(input byte_t b);
		return (b & 8'hC0) == 8'h80;
	endfunction

	function automatic logic is_lead2(input byte_t b);
		return (b & 8'hE0) == 8'hC0;
	endfunction

	function automatic logic is_lead3(input byte_t b);
		return (b & 8'hF0) == 8'hE0;
	endfunction

endpackage

// File: rtl/core/utf8_latin1_glyph_mapper.sv
// After its byte is accepted, a result is registered in the decode stage, then in the
// output register. Bytes are taken one per cycle while the output is not stalled; a
// byte that yields several results holds the decode stage while they leave the output
// register one per cycle. Bytes that only open or extend a sequence yield no result.
// Reset drops any pending sequence and loads first/last glyph codes 32 and 126.
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 glyph mapper
// Decodes 1- to 3-byte UTF-8, clamps to Latin-1 and maps to a glyph offset.
// ----------------------------------------------------------------------------
`include "utf8_latin1_glyph_mapper_defines.svh"

module utf8_latin1_glyph_mapper
	import u8gm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] text_byte
	input  logic        s_axis_tlast,  // end_of_text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] code_point, [15:8] glyph_index
	output logic        m_axis_tuser,  // has_glyph
	output logic        m_axis_tlast   // run_last
);

	byte_t    first_glyph_q, last_glyph_q;
	byte_t    held_lead_q, held_second_q;
	res_cnt_t held_count_q;

	logic     valid_s1;
	res_cnt_t n_s1, ptr_s1;
	byte_t    cp_s1 [RES_MAX];

	logic     valid_s2;
	byte_t    code_s2, glyph_s2;
	logic     has_s2, last_s2;

	logic     s_accept, s2_free, s2_load, s1_last, s1_drain;
	byte_t    in_byte;
	res_cnt_t cnt_eff, k, n_new, nxt_count;
	logic     has_v, do_fresh;
	byte_t    v, nxt_lead, nxt_second;
	byte_t    cp_new [RES_MAX];
	byte_t    cur_cp, look;
	logic     cur_in, look_in;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_glyph_q <= FIRST_GLYPH_RST;
			last_glyph_q  <= LAST_GLYPH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FIRST_GLYPH: first_glyph_q <= cfg_data;
				REG_LAST_GLYPH:  last_glyph_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// decode
	assign in_byte = s_axis_tdata;
	assign cnt_eff = (held_count_q == 2'd3) ? 2'd2 : held_count_q;

	always_comb begin
		k          = '0;
		has_v      = 1'b0;
		v          = in_byte;
		do_fresh   = 1'b0;
		nxt_count  = held_count_q;
		nxt_lead   = held_lead_q;
		nxt_second = held_second_q;
		if (s_axis_tlast) begin
			k          = cnt_eff;
			nxt_count  = '0;
			nxt_lead   = '0;
			nxt_second = '0;
		end else if (cnt_eff == 2'd0) begin
			do_fresh = 1'b1;
		end else if (!is_cont(in_byte)) begin
			k         = cnt_eff;
			nxt_count = '0;
			do_fresh  = 1'b1;
		end else if (cnt_eff == 2'd1 && is_lead2(held_lead_q)) begin
			has_v     = 1'b1;
			v         = (held_lead_q[4:2] != 3'd0) ? QMARK
				: {held_lead_q[1:0], in_byte[5:0]};
			nxt_count = '0;
		end else if (cnt_eff == 2'd1) begin
			nxt_second = in_byte;
			nxt_count  = 2'd2;
		end else begin
			has_v     = 1'b1;
			v         = (held_lead_q[3:0] != 4'd0 || held_second_q[5:2] != 4'd0) ? QMARK
				: {held_second_q[1:0], in_byte[5:0]};
			nxt_count = '0;
		end
		if (do_fresh) begin
			if (!in_byte[7]) begin
				has_v = 1'b1;
				v     = in_byte;
			end else if (is_lead2(in_byte) || is_lead3(in_byte)) begin
				nxt_lead  = in_byte;
				nxt_count = 2'd1;
			end else begin
				has_v = 1'b1;
				v     = QMARK;
			end
		end
	end

	assign n_new = k + res_cnt_t'(has_v);

	always_comb begin
		for (int i = 0; i < RES_MAX; i++) begin
			cp_new[i] = (res_cnt_t'(i) < k) ? QMARK : v;
		end
	end

	// handshake
	assign s2_free       = !valid_s2 || m_axis_tready;
	assign s2_load       = valid_s1 && s2_free;
	assign s1_last       = (ptr_s1 == n_s1 - 2'd1);
	assign s1_drain      = s2_load && s1_last;
	assign s_axis_tready = !valid_s1 || s1_drain;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
		end else if (s_accept) begin
			held_count_q <= nxt_count;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			held_lead_q   <= nxt_lead;
			held_second_q <= nxt_second;
		end
	end

	// decode stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ptr_s1   <= '0;
			n_s1     <= '0;
		end else if (s_accept && n_new != 2'd0) begin
			valid_s1 <= 1'b1;
			ptr_s1   <= '0;
			n_s1     <= n_new;
		end else if (s1_drain) begin
			valid_s1 <= 1'b0;
		end else if (s2_load) begin
			ptr_s1 <= ptr_s1 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept && n_new != 2'd0) begin
			cp_s1 <= cp_new;
		end
	end

	// glyph lookup
	assign cur_cp  = cp_s1[ptr_s1];
	assign cur_in  = (cur_cp >= first_glyph_q) && (cur_cp <= last_glyph_q);
	assign look    = cur_in ? cur_cp : QMARK;
	assign look_in = (look >= first_glyph_q) && (look <= last_glyph_q);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			code_s2  <= cur_cp;
			glyph_s2 <= look_in ? look - first_glyph_q : '0;
			has_s2   <= look_in;
			last_s2  <= s1_last;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {glyph_s2, code_s2};
	assign m_axis_tuser  = has_s2;
	assign m_axis_tlast  = last_s2;

	`U8GM_ASSERT(a_ptr_in_run, valid_s1 |-> (n_s1 != 2'd0 && ptr_s1 < n_s1), "result pointer past run")
	`U8GM_NEVER(a_count_three, held_count_q == 2'd3, "pending count reached three")
	`U8GM_ASSERT(a_run_continues, (s2_load && !s1_last) |=> valid_s1, "decode stage lost a result")
	`U8GM_ASSERT(a_eot_clears, (s_accept && s_axis_tlast) |=> held_count_q == 2'd0, "flush left bytes pending")
	`U8GM_ASSERT(a_no_glyph_zero, (valid_s2 && !has_s2) |-> glyph_s2 == 8'd0, "missing glyph with nonzero index")

endmodule

// File: tb/tb_utf8_latin1_glyph_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 glyph mapper testbench
// Streams directed and random UTF-8 text through the mapper, with random gaps
// and stalls on both sides, a long output hold-off and several glyph ranges.
// Each result beat is checked field by field against an in-bench decoder.
// ----------------------------------------------------------------------------
module tb_utf8_latin1_glyph_mapper;
	import u8gm_pkg::*;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned MAX_REPORTS = 200;
	localparam int unsigned SETTLE_CYCLES = 6;

	typedef struct packed {
		byte_t code_point;
		byte_t glyph_index;
		logic  has_glyph;
		logic  run_last;
	} glyph_res_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_reg_t    cfg_index;
	logic [7:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;  // [7:0] text_byte
	logic        s_axis_tlast;  // end_of_text
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;  // [7:0] code_point, [15:8] glyph_index
	logic        m_axis_tuser;  // has_glyph
	logic        m_axis_tlast;  // run_last

	glyph_res_t  glyph_fifo [$];
	byte_t       first_code;
	byte_t       last_code;
	byte_t       held_lead;
	byte_t       held_second;
	logic [1:0]  held_cnt;
	int unsigned mismatch_cnt = 0;
	int unsigned stall_cycles = 0;
	int unsigned hold_cycles = 0;
	int unsigned beats_sent = 0;
	bit          src_idle = 1'b0;
	bit          sink_idle = 1'b0;

	utf8_latin1_glyph_mapper dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// decoder
	// ------------------------------------------------------------------------
	function automatic glyph_res_t map_glyph(input byte_t c);
		glyph_res_t r;
		byte_t      look;
		look = c;
		if (look < first_code || look > last_code)
			look = QMARK;
		r.code_point = c;
		r.run_last   = 1'b0;
		if (look < first_code || look > last_code) begin
			r.glyph_index = 8'd0;
			r.has_glyph   = 1'b0;
		end else begin
			r.glyph_index = look - first_code;
			r.has_glyph   = 1'b1;
		end
		return r;
	endfunction

	function automatic void decode_text_byte(input byte_t b, input logic eot);
		glyph_res_t  res [3];
		int          n;
		logic [1:0]  cnt;
		logic [15:0] cp;
		n   = 0;
		cnt = (held_cnt == 2'd3) ? 2'd2 : held_cnt;
		if (eot) begin
			for (int i = 0; i < cnt; i++) begin
				res[n] = map_glyph(QMARK);
				n = n + 1;
			end
			held_cnt    = 2'd0;
			held_lead   = 8'd0;
			held_second = 8'd0;
		end else begin
			// broken sequence: flush pending bytes, then decode afresh
			if (cnt != 2'd0 && b[7:6] != 2'b10) begin
				for (int i = 0; i < cnt; i++) begin
					res[n] = map_glyph(QMARK);
					n = n + 1;
				end
				cnt      = 2'd0;
				held_cnt = 2'd0;
			end
			if (cnt == 2'd0) begin
				if (!b[7]) begin
					res[n] = map_glyph(b);
					n = n + 1;
				end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110) begin
					held_lead = b;
					held_cnt  = 2'd1;
				end else begin
					res[n] = map_glyph(QMARK);
					n = n + 1;
				end
			end else if (cnt == 2'd1 && held_lead[7:5] == 3'b110) begin
				cp = {5'd0, held_lead[4:0], b[5:0]};
				res[n] = map_glyph(cp > 16'hFF ? QMARK : cp[7:0]);
				n = n + 1;
				held_cnt = 2'd0;
			end else if (cnt == 2'd1) begin
				held_second = b;
				held_cnt    = 2'd2;
			end else begin
				cp = {held_lead[3:0], held_second[5:0], b[5:0]};
				res[n] = map_glyph(cp > 16'hFF ? QMARK : cp[7:0]);
				n = n + 1;
				held_cnt = 2'd0;
			end
		end
		if (n > 0)
			res[n-1].run_last = 1'b1;
		for (int i = 0; i < n; i++)
			glyph_fifo.push_back(res[i]);
	endfunction

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic byte_t rand_cont();
		return 8'h80 | byte_t'($urandom_range(0, 63));
	endfunction

	task automatic send_text_beat(input byte_t b, input logic eot);
		int unsigned gap;
		gap = src_idle ? pick_gap() : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eot;
		do @(posedge clk); while (!s_axis_tready);
		if (!(eot && held_cnt == 2'd0))
			beats_sent++;
		decode_text_byte(b, eot);
	endtask

	// waits for the last result and lets the block go idle
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (glyph_fifo.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_glyph_range(input byte_t lo, input byte_t hi);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= REG_FIRST_GLYPH;
		cfg_data  <= lo;
		do @(posedge clk); while (!cfg_ready);
		first_code = lo;
		cfg_index <= REG_LAST_GLYPH;
		cfg_data  <= hi;
		do @(posedge clk); while (!cfg_ready);
		last_code = hi;
		cfg_valid <= 1'b0;
	endtask

	// one well-formed sequence, a broken one, a flush or noise
	task automatic send_text_unit();
		int unsigned pick;
		byte_t       lead;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			send_text_beat(byte_t'($urandom_range(0, 127)), 1'b0);
		end else if (pick < 50) begin
			send_text_beat(8'hC0 | byte_t'($urandom_range(0, 31)), 1'b0);
			send_text_beat(rand_cont(), 1'b0);
		end else if (pick < 65) begin
			send_text_beat(8'hE0 | byte_t'($urandom_range(0, 15)), 1'b0);
			send_text_beat(rand_cont(), 1'b0);
			send_text_beat(rand_cont(), 1'b0);
		end else if (pick < 78) begin
			if ($urandom_range(0, 1))
				lead = 8'hC0 | byte_t'($urandom_range(0, 31));
			else
				lead = 8'hE0 | byte_t'($urandom_range(0, 15));
			send_text_beat(lead, 1'b0);
			if (lead[5] && $urandom_range(0, 1))
				send_text_beat(rand_cont(), 1'b0);
			send_text_beat(byte_t'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
		end else if (pick < 86) begin
			send_text_beat(byte_t'($urandom_range(0, 255)), 1'b1);
		end else begin
			send_text_beat(byte_t'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_directed_text();
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		send_text_beat(8'h00, 1'b0);
		send_text_beat(8'h7F, 1'b0);
		send_text_beat(8'h1F, 1'b0);
		send_text_beat(8'h55, 1'b1);  // empty flush
		send_text_beat(8'hC2, 1'b0);
		send_text_beat(8'hA9, 1'b0);
		send_text_beat(8'hC3, 1'b0);
		send_text_beat(8'hBF, 1'b0);
		send_text_beat(8'hC4, 1'b0);  // U+0100, above Latin-1
		send_text_beat(8'h80, 1'b0);
		send_text_beat(8'hE0, 1'b0);  // overlong
		send_text_beat(8'h83, 1'b0);
		send_text_beat(8'hBF, 1'b0);
		send_text_beat(8'hEF, 1'b0);
		send_text_beat(8'hBF, 1'b0);
		send_text_beat(8'hBF, 1'b0);
		send_text_beat(8'hBF, 1'b0);  // stray continuation
		send_text_beat(8'hF0, 1'b0);  // 4-byte lead
		send_text_beat(8'hFF, 1'b0);
		send_text_beat(8'hC3, 1'b0);
		send_text_beat(8'h41, 1'b0);  // breaks after one byte
		send_text_beat(8'hE2, 1'b0);
		send_text_beat(8'h82, 1'b0);
		send_text_beat(8'hF8, 1'b0);  // two flushed plus invalid
		send_text_beat(8'hE2, 1'b0);
		send_text_beat(8'h82, 1'b0);
		send_text_beat(8'hA5, 1'b1);  // flush of two pending
		send_text_beat(8'hDF, 1'b0);
		send_text_beat(8'h00, 1'b1);
		settle();
	endtask

	task automatic test_glyph_ranges();
		byte_t lo [8] = '{8'd0, 8'd255, 8'd65, 8'd0, 8'd255, 8'd63, 8'd200, 8'd0};
		byte_t hi [8] = '{8'd255, 8'd0, 8'd90, 8'd0, 8'd255, 8'd63, 8'd255, 8'd62};
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		for (int k = 0; k < 8; k++) begin
			set_glyph_range(lo[k], hi[k]);
			repeat (12) send_text_unit();
		end
		settle();
	endtask

	task automatic test_output_backpressure();
		src_idle    = 1'b0;
		sink_idle   = 1'b0;
		hold_cycles = 80;
		for (int k = 0; k < 12; k++) begin
			send_text_beat(byte_t'($urandom_range(0, 127)), 1'b0);
			send_text_beat(8'hE2, 1'b0);
			send_text_beat(8'h82, 1'b0);
			send_text_beat(8'hFE, 1'b0);
		end
		settle();
	endtask

	task automatic test_random_text();
		byte_t lo;
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		for (int k = 0; k < 4; k++) begin
			lo = byte_t'($urandom_range(0, 127));
			set_glyph_range(lo, lo + byte_t'($urandom_range(0, 128)));
			beats_sent = 0;
			while (beats_sent < 60)
				send_text_unit();
		end
		settle();
	endtask

	// ------------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int unsigned len;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			len = 0;
			if (hold_cycles != 0) begin
				len = hold_cycles;
				hold_cycles = 0;
			end else if (sink_idle && $urandom_range(0, 3) == 0) begin
				len = pick_gap();
			end
			if (len != 0) begin
				m_axis_tready <= 1'b0;
				repeat (len) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_glyph_beat
		glyph_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (glyph_fifo.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTS)
					$error("result beat with nothing expected: tdata %h", m_axis_tdata);
			end else begin
				want = glyph_fifo.pop_front();
				if (m_axis_tdata[7:0] !== want.code_point) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$error("code_point: expected %0d, got %0d",
							want.code_point, m_axis_tdata[7:0]);
				end
				if (m_axis_tdata[15:8] !== want.glyph_index) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$error("glyph_index: expected %0d, got %0d",
							want.glyph_index, m_axis_tdata[15:8]);
				end
				if (m_axis_tuser !== want.has_glyph) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$error("has_glyph: expected %0d, got %0d",
							want.has_glyph, m_axis_tuser);
				end
				if (m_axis_tlast !== want.run_last) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$error("run_last: expected %0d, got %0d",
							want.run_last, m_axis_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("utf8_latin1_glyph_mapper test failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_FIRST_GLYPH;
		cfg_data      = 8'd0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'd0;
		s_axis_tlast  = 1'b0;
		first_code    = FIRST_GLYPH_RST;
		last_code     = LAST_GLYPH_RST;
		held_lead     = 8'd0;
		held_second   = 8'd0;
		held_cnt      = 2'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_text();
		test_glyph_ranges();
		test_output_backpressure();
		test_random_text();
		settle();

		if (mismatch_cnt == 0 && glyph_fifo.size() == 0)
			$display("utf8_latin1_glyph_mapper test passed");
		else
			$display("utf8_latin1_glyph_mapper test failed");
		$finish;
	end

endmodule
